/* rtl/dets_pkg.sv */
// Shared types and constants for the dual envelope transient shaper.
package dets_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoeffW  = 24;
  localparam int unsigned EnvW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 25;
  localparam int unsigned MulPW = MulAW + MulBW;

  localparam int unsigned MaskW = 17;
  localparam int unsigned LevW  = 19;
  localparam int unsigned GainW = 35;

  localparam logic [MaskW-1:0] MaskOne       = 17'd65536;
  localparam logic [15:0]      NineTenthsQ16 = 16'd58982;

  localparam logic [CoeffW-1:0] FastAttackRst  = 24'd15651670;
  localparam logic [CoeffW-1:0] FastReleaseRst = 24'd16742299;
  localparam logic [CoeffW-1:0] SlowAttackRst  = 24'd16767233;
  localparam logic [CoeffW-1:0] SlowReleaseRst = 24'd16775469;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FAST_ATTACK  = 3'd0,
    CFG_FAST_RELEASE = 3'd1,
    CFG_SLOW_ATTACK  = 3'd2,
    CFG_SLOW_RELEASE = 3'd3,
    CFG_ATTACK_AMT   = 3'd4,
    CFG_SUSTAIN_AMT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoeffW-1:0]         fast_attack;
    logic [CoeffW-1:0]         fast_release;
    logic [CoeffW-1:0]         slow_attack;
    logic [CoeffW-1:0]         slow_release;
    logic signed [SampleW-1:0] attack_amount;
    logic signed [SampleW-1:0] sustain_amount;
  } cfg_t;

  typedef struct packed {
    logic                    en;
    logic signed [MulAW-1:0] a;
    logic signed [MulBW-1:0] b;
  } mul_req_t;

endpackage

/* rtl/dets_cfg_regs.sv */
// Configuration register file of the transient shaper.
module dets_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dets_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [dets_pkg::CfgDataW-1:0]   cfg_data_i,
  output dets_pkg::cfg_t                  cfg_o
);
  import dets_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FAST_ATTACK:  cfg_d.fast_attack    = cfg_data_i;
        CFG_FAST_RELEASE: cfg_d.fast_release   = cfg_data_i;
        CFG_SLOW_ATTACK:  cfg_d.slow_attack    = cfg_data_i;
        CFG_SLOW_RELEASE: cfg_d.slow_release   = cfg_data_i;
        CFG_ATTACK_AMT:   cfg_d.attack_amount  = $signed(cfg_data_i[SampleW-1:0]);
        CFG_SUSTAIN_AMT:  cfg_d.sustain_amount = $signed(cfg_data_i[SampleW-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_attack    <= FastAttackRst;
      cfg_q.fast_release   <= FastReleaseRst;
      cfg_q.slow_attack    <= SlowAttackRst;
      cfg_q.slow_release   <= SlowReleaseRst;
      cfg_q.attack_amount  <= '0;
      cfg_q.sustain_amount <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/dets_mul.sv */
// Shared signed multiplier with a registered product.
module dets_mul (
  input  logic                                clk_i,
  input  dets_pkg::mul_req_t                  req_i,
  output logic signed [dets_pkg::MulPW-1:0]   prod_o
);
  import dets_pkg::*;

  logic signed [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= MulPW'(req_i.a) * MulPW'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/dual_envelope_transient_shaper_top.sv */
// Top level of the dual envelope transient shaper with its sequencer.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o   sample_in_i
// out       output     out_valid_o/out_stall_i sample_out_o
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each word passes through S_FAST, S_SLOW, S_LEVA, S_LEVS, S_MLA, S_MLS, S_GAIN, S_MULG and S_OUT.
// The next word is accepted only once the sequencer is back in S_IDLE, never while one is in flight.
// This sequence is set by the seven products that pass through one shared multiplier.
// Reset restores the default coefficients and clears both envelopes.
// A new word is accepted while the previous result still waits in the output register.
// The sequencer holds its last step while the output register is full and stalled.
module dual_envelope_transient_shaper_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [dets_pkg::SampleW-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dets_pkg::SampleW-1:0] sample_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dets_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dets_pkg::CfgDataW-1:0]       cfg_data_i
);
  import dets_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FAST,
    S_SLOW,
    S_LEVA,
    S_LEVS,
    S_MLA,
    S_MLS,
    S_GAIN,
    S_MULG,
    S_OUT
  } state_e;

  state_e state_q;
  cfg_t   cfg;

  logic [EnvW-1:0]           fast_q;
  logic [EnvW-1:0]           slow_q;
  logic                      neg_q;
  logic [SampleW-1:0]        xmag_q;
  logic [MaskW-1:0]          mask_q;
  logic signed [LevW-1:0]    lev_a_q;
  logic signed [LevW-1:0]    lev_s_q;
  logic signed [GainW-1:0]   acc_q;
  logic signed [GainW-1:0]   gain_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_q;

  mul_req_t                mul_req;
  logic signed [MulPW-1:0] prod;

  logic [EnvW-1:0]      m;
  logic [EnvW:0]        diff_f;
  logic [EnvW:0]        diff_s;
  logic [CoeffW-1:0]    coef_f;
  logic [CoeffW-1:0]    coef_s;
  logic [MulPW-1:0]     env_sum;
  logic [EnvW-1:0]      env_new;
  logic [SampleW-1:0]   amag_a;
  logic [SampleW-1:0]   amag_s;
  logic [EnvW-1:0]      rnd_lev;
  logic signed [LevW-1:0] lev_neg;
  logic [EnvW-1:0]      d;
  logic [35:0]          d12;
  logic [20:0]          scaled;
  logic [MaskW-1:0]     mask_d;
  logic [51:0]          out_sum;
  logic [20:0]          r;
  logic signed [SampleW-1:0] res;
  logic                 in_acc;
  logic                 out_free;

  dets_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dets_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign out_free     = !out_valid_q || !out_stall_i;

  assign m      = {xmag_q, 16'h0};
  assign diff_f = {1'b0, fast_q} - {1'b0, m};
  assign diff_s = {1'b0, slow_q} - {1'b0, m};
  assign coef_f = (m > fast_q) ? cfg.fast_attack : cfg.fast_release;
  assign coef_s = (m > slow_q) ? cfg.slow_attack : cfg.slow_release;

  assign env_sum = prod + {4'h0, m, 24'h0} + MulPW'(64'h800000);
  assign env_new = env_sum[55:24];

  assign amag_a = cfg.attack_amount[SampleW-1] ? (~cfg.attack_amount + 16'd1)
                                               : cfg.attack_amount;
  assign amag_s = cfg.sustain_amount[SampleW-1] ? (~cfg.sustain_amount + 16'd1)
                                                : cfg.sustain_amount;
  assign rnd_lev = prod[EnvW-1:0] + 32'd32768;
  assign lev_neg = -$signed({3'b000, rnd_lev[31:16]});

  assign d      = (fast_q > slow_q) ? (fast_q - slow_q) : '0;
  assign d12    = {1'b0, d, 3'b000} + {2'b00, d, 2'b00};
  assign scaled = d12[35:15];
  assign mask_d = (scaled > 21'(MaskOne)) ? MaskOne : scaled[MaskW-1:0];

  assign out_sum = prod[51:0] + 52'h40000000;
  assign r       = out_sum[51:31];

  always_comb begin
    if (!neg_q) begin
      res = (r > 21'd32767) ? 16'sh7fff : $signed(r[SampleW-1:0]);
    end else begin
      res = (r > 21'd32768) ? 16'sh8000 : $signed(~r[SampleW-1:0] + 16'd1);
    end
  end

  always_comb begin
    mul_req.en = 1'b0;
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (state_q)
      S_FAST: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed({{2{diff_f[EnvW]}}, diff_f});
        mul_req.b  = $signed({1'b0, coef_f});
      end
      S_SLOW: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed({{2{diff_s[EnvW]}}, diff_s});
        mul_req.b  = $signed({1'b0, coef_s});
      end
      S_LEVA: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed({19'h0, amag_a});
        mul_req.b  = $signed({9'h0, NineTenthsQ16});
      end
      S_LEVS: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed({19'h0, amag_s});
        mul_req.b  = $signed({9'h0, NineTenthsQ16});
      end
      S_MLA: begin
        mul_req.en = 1'b1;
        mul_req.a  = MulAW'(lev_a_q);
        mul_req.b  = $signed({8'h0, mask_q});
      end
      S_MLS: begin
        mul_req.en = 1'b1;
        mul_req.a  = MulAW'(lev_s_q);
        mul_req.b  = $signed({8'h0, MaskOne - mask_q});
      end
      S_MULG: begin
        mul_req.en = 1'b1;
        mul_req.a  = gain_q;
        mul_req.b  = $signed({9'h0, xmag_q});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fast_q      <= '0;
      slow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_FAST;
          end
        end
        S_FAST: state_q <= S_SLOW;
        S_SLOW: begin
          fast_q  <= env_new;
          state_q <= S_LEVA;
        end
        S_LEVA: begin
          slow_q  <= env_new;
          state_q <= S_LEVS;
        end
        S_LEVS: state_q <= S_MLA;
        S_MLA:  state_q <= S_MLS;
        S_MLS:  state_q <= S_GAIN;
        S_GAIN: state_q <= S_MULG;
        S_MULG: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_q  <= sample_in_i[SampleW-1];
          xmag_q <= sample_in_i[SampleW-1] ? (~sample_in_i + 16'd1) : sample_in_i;
        end
      end
      S_LEVS: begin
        lev_a_q <= cfg.attack_amount[SampleW-1] ? lev_neg
                                                : LevW'({cfg.attack_amount, 2'b00});
        mask_q  <= mask_d;
      end
      S_MLA: begin
        lev_s_q <= cfg.sustain_amount[SampleW-1] ? lev_neg
                                                 : LevW'({cfg.sustain_amount, 1'b0});
      end
      S_MLS:  acc_q  <= $signed(35'h080000000) + prod[GainW-1:0];
      S_GAIN: gain_q <= acc_q + prod[GainW-1:0];
      S_OUT: begin
        if (out_free) begin
          out_q <= res;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_env_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> ($stable(fast_q) && $stable(slow_q)))
    else $error("envelope changed while no word was in flight");

  a_out_from_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result shown outside of the final step");

  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MLA) |-> (mask_q <= MaskOne))
    else $error("transient mask above unity");

  a_gain_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MULG) |-> !gain_q[GainW-1])
    else $error("gain went negative");

  a_stalled_holds_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_o && out_stall_i) |=> (state_q == S_OUT))
    else $error("sequencer left the final step while the output was full");
`endif

endmodule
